// ===== sv/tls_pkg.sv =====
// Shared types, register map and reset constants for the traffic light sequencer.
package tls_pkg;

  localparam int unsigned TimerW  = 17;
  localparam int unsigned FilterW = 16;
  localparam int unsigned FlashW  = 10;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  localparam logic [TimerW-1:0]  GreenEndRst   = 17'd60000;
  localparam logic [TimerW-1:0]  YellowEndRst  = 17'd65000;
  localparam logic [TimerW-1:0]  CycleEndRst   = 17'd95000;
  localparam logic [FilterW-1:0] FilterRst     = 16'd50;
  localparam logic [FlashW-1:0]  FlashRst      = 10'd1000;

  // Register indexes; byte address is four times the index.
  typedef enum logic [2:0] {
    REG_GREEN_END  = 3'd0,
    REG_YELLOW_END = 3'd1,
    REG_CYCLE_END  = 3'd2,
    REG_FILTER     = 3'd3,
    REG_FLASH      = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_GREEN  = 2'd0,
    PH_YELLOW = 2'd1,
    PH_RED    = 2'd2
  } phase_t;

  // Bit positions inside the lamp register.
  localparam int unsigned LampGreen  = 0;
  localparam int unsigned LampYellow = 1;
  localparam int unsigned LampRed    = 2;
  localparam int unsigned LampCar    = 3;

  typedef struct packed {
    logic [TimerW-1:0]  green_end;
    logic [TimerW-1:0]  yellow_end;
    logic [TimerW-1:0]  cycle_end;
    logic [FilterW-1:0] filter;
    logic [FlashW-1:0]  flash;
  } cfg_t;

  typedef struct packed {
    logic       green_lamp;
    logic       yellow_lamp;
    logic       red_lamp;
    logic       car_lamp;
    logic       key_led;
    logic [1:0] light_phase;
  } res_t;

endpackage

// ===== sv/tls_cfg.sv =====
// APB-style register file holding the phase limits, filter length and flash period.
module tls_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tls_pkg::AddrW-1:0]   paddr,
  input  logic [tls_pkg::DataW-1:0]   pwdata,
  output logic [tls_pkg::DataW-1:0]   prdata,
  output tls_pkg::cfg_t               cfg
);

  tls_pkg::cfg_t     cfg_r;
  tls_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx   = tls_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.green_end  <= tls_pkg::GreenEndRst;
      cfg_r.yellow_end <= tls_pkg::YellowEndRst;
      cfg_r.cycle_end  <= tls_pkg::CycleEndRst;
      cfg_r.filter     <= tls_pkg::FilterRst;
      cfg_r.flash      <= tls_pkg::FlashRst;
    end else if (wr_en) begin
      case (idx)
        tls_pkg::REG_GREEN_END:  cfg_r.green_end  <= pwdata[tls_pkg::TimerW-1:0];
        tls_pkg::REG_YELLOW_END: cfg_r.yellow_end <= pwdata[tls_pkg::TimerW-1:0];
        tls_pkg::REG_CYCLE_END:  cfg_r.cycle_end  <= pwdata[tls_pkg::TimerW-1:0];
        tls_pkg::REG_FILTER:     cfg_r.filter     <= pwdata[tls_pkg::FilterW-1:0];
        tls_pkg::REG_FLASH:      cfg_r.flash      <= pwdata[tls_pkg::FlashW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tls_pkg::REG_GREEN_END:  prdata = {{(tls_pkg::DataW-tls_pkg::TimerW){1'b0}},
                                         cfg_r.green_end};
      tls_pkg::REG_YELLOW_END: prdata = {{(tls_pkg::DataW-tls_pkg::TimerW){1'b0}},
                                         cfg_r.yellow_end};
      tls_pkg::REG_CYCLE_END:  prdata = {{(tls_pkg::DataW-tls_pkg::TimerW){1'b0}},
                                         cfg_r.cycle_end};
      tls_pkg::REG_FILTER:     prdata = {{(tls_pkg::DataW-tls_pkg::FilterW){1'b0}},
                                         cfg_r.filter};
      tls_pkg::REG_FLASH:      prdata = {{(tls_pkg::DataW-tls_pkg::FlashW){1'b0}},
                                         cfg_r.flash};
      default:                 prdata = '0;
    endcase
  end

endmodule

// ===== sv/tls_step.sv =====
// Per-tick state update: phase timer, blink counter, phase sequencer and sensor filter.
module tls_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          pin,
  input  tls_pkg::cfg_t cfg,
  output tls_pkg::res_t res
);

  tls_pkg::phase_t                phase_r, phase_nxt;
  logic [tls_pkg::TimerW-1:0]     ptimer_r, ptimer_nxt;
  logic                           prun_r, prun_nxt;
  logic                           det_en_r, det_en_nxt;
  logic [tls_pkg::FilterW-1:0]    fcount_r, fcount_nxt;
  logic                           frun_r, frun_nxt;
  logic                           lock_r, lock_nxt;
  logic                           blink_en_r, blink_en_nxt;
  logic                           key_r, key_nxt;
  logic [3:0]                     lamp_r, lamp_nxt;
  logic [tls_pkg::FlashW-1:0]     bcount_r, bcount_nxt;
  logic [tls_pkg::FlashW-1:0]     bcount_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= tls_pkg::PH_GREEN;
      ptimer_r   <= '0;
      prun_r     <= 1'b0;
      det_en_r   <= 1'b0;
      fcount_r   <= '0;
      frun_r     <= 1'b0;
      lock_r     <= 1'b0;
      blink_en_r <= 1'b1;
      key_r      <= 1'b0;
      lamp_r     <= '0;
      bcount_r   <= '0;
    end else if (en) begin
      phase_r    <= phase_nxt;
      ptimer_r   <= ptimer_nxt;
      prun_r     <= prun_nxt;
      det_en_r   <= det_en_nxt;
      fcount_r   <= fcount_nxt;
      frun_r     <= frun_nxt;
      lock_r     <= lock_nxt;
      blink_en_r <= blink_en_nxt;
      key_r      <= key_nxt;
      lamp_r     <= lamp_nxt;
      bcount_r   <= bcount_nxt;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    prun_nxt     = prun_r;
    det_en_nxt   = det_en_r;
    frun_nxt     = frun_r;
    lock_nxt     = lock_r;
    blink_en_nxt = blink_en_r;
    key_nxt      = key_r;
    lamp_nxt     = lamp_r;

    // Both timers saturate rather than wrap.
    if (!prun_r) begin
      ptimer_nxt = '0;
    end else if (ptimer_r != '1) begin
      ptimer_nxt = ptimer_r + 1'b1;
    end else begin
      ptimer_nxt = ptimer_r;
    end
    if (frun_r && (fcount_r != '1)) begin
      fcount_nxt = fcount_r + 1'b1;
    end else begin
      fcount_nxt = fcount_r;
    end

    bcount_inc = bcount_r + 1'b1;
    if (bcount_inc >= cfg.flash) begin
      bcount_nxt = '0;
      if (blink_en_r) begin
        key_nxt = !key_r;
      end
    end else begin
      bcount_nxt = bcount_inc;
    end

    case (phase_r)
      tls_pkg::PH_GREEN: begin
        prun_nxt                     = 1'b1;
        lamp_nxt[tls_pkg::LampGreen] = 1'b1;
        lamp_nxt[tls_pkg::LampRed]   = 1'b0;
        det_en_nxt                   = 1'b0;
        if (ptimer_nxt >= cfg.green_end) begin
          phase_nxt = tls_pkg::PH_YELLOW;
        end
      end
      tls_pkg::PH_YELLOW: begin
        lamp_nxt[tls_pkg::LampGreen]  = 1'b0;
        lamp_nxt[tls_pkg::LampYellow] = 1'b1;
        det_en_nxt                    = 1'b1;
        if (ptimer_nxt >= cfg.yellow_end) begin
          phase_nxt = tls_pkg::PH_RED;
        end
      end
      tls_pkg::PH_RED: begin
        lamp_nxt[tls_pkg::LampGreen]  = 1'b0;
        lamp_nxt[tls_pkg::LampYellow] = 1'b0;
        lamp_nxt[tls_pkg::LampRed]    = 1'b1;
        if (ptimer_nxt >= cfg.cycle_end) begin
          phase_nxt  = tls_pkg::PH_GREEN;
          ptimer_nxt = '0;
          prun_nxt   = 1'b0;
        end
      end
      default: ;
    endcase

    // Detection looks at the enable as the phase logic just left it.
    if (det_en_nxt) begin
      if (pin) begin
        lock_nxt     = 1'b0;
        frun_nxt     = 1'b0;
        fcount_nxt   = '0;
        blink_en_nxt = 1'b1;
      end else if (!lock_r) begin
        frun_nxt = 1'b1;
        if (fcount_nxt >= cfg.filter) begin
          frun_nxt                   = 1'b0;
          lock_nxt                   = 1'b1;
          lamp_nxt[tls_pkg::LampCar] = 1'b1;
          key_nxt                    = 1'b1;
          blink_en_nxt               = 1'b0;
        end
      end
    end else begin
      frun_nxt                   = 1'b0;
      lamp_nxt[tls_pkg::LampCar] = 1'b0;
    end

    res.green_lamp  = lamp_nxt[tls_pkg::LampGreen];
    res.yellow_lamp = lamp_nxt[tls_pkg::LampYellow];
    res.red_lamp    = lamp_nxt[tls_pkg::LampRed];
    res.car_lamp    = lamp_nxt[tls_pkg::LampCar];
    res.key_led     = key_nxt;
    res.light_phase = phase_nxt;
  end

  // The car lamp is only ever lit while detection is on.
  a_car_needs_detect: assert property (@(posedge clk) disable iff (!rst_n)
    lamp_r[tls_pkg::LampCar] |-> det_en_r)
    else $error("car lamp lit with detection off");

  // Stopping the blink always leaves the key LED forced on.
  a_blink_off_key_on: assert property (@(posedge clk) disable iff (!rst_n)
    !blink_en_r |-> key_r)
    else $error("blinking stopped but key LED is off");

  // A locked detector never keeps its filter running.
  a_lock_stops_filter: assert property (@(posedge clk) disable iff (!rst_n)
    lock_r |-> !frun_r)
    else $error("filter running while detection is locked");

endmodule

// ===== sv/traffic_light_sequencer.sv =====
// Top level of the traffic light sequencer: stream ports, input stage and result register.
//
// Each input beat is one 1 ms tick carrying the sensor pin level; each tick yields exactly
// one result beat with the green, yellow, red and car lamp drives, the key LED and the
// current phase code. A beat is registered on entry, the whole tick update (timers,
// blink counter, phase sequencer, sensor filter) is done by short logic, and the result
// lands in an output register, so the block takes one tick per clock cycle while the
// result consumer does not stall. The input stage and the result register each hold one
// beat, so a stalled result consumer holds back at most two ticks before in_tready drops.
// The phase limits, filter length and flash period sit in an APB-style register file at
// byte addresses 0, 4, 8, 12 and 16; write them only while no tick is in flight.
module traffic_light_sequencer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,    // [0] pin_level, [7:1] zero
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [0] green_lamp, [1] yellow_lamp, [2] red_lamp, [3] car_lamp, [4] key_led,
  // [6:5] light_phase, [7] zero
  output logic [7:0]                  out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tls_pkg::AddrW-1:0]   cfg_paddr,
  input  logic [tls_pkg::DataW-1:0]   cfg_pwdata,
  output logic [tls_pkg::DataW-1:0]   cfg_prdata,
  output logic                        cfg_pready
);

  tls_pkg::cfg_t cfg;
  tls_pkg::res_t res;

  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_pin_r;
  logic          out_valid_r, out_valid_nxt;
  tls_pkg::res_t out_res_r;
  logic          in_acc;
  logic          advance;

  assign cfg_pready = 1'b1;

  tls_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // The tick in the input stage moves on whenever the result register is free or
  // is being drained in this same cycle.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  tls_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .pin   (s1_pin_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pin_r <= in_tdata[0];
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.light_phase, out_res_r.key_led, out_res_r.car_lamp,
                       out_res_r.red_lamp, out_res_r.yellow_lamp, out_res_r.green_lamp};

  // A tick that moves on from the input stage always shows up as a result beat.
  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("tick advanced but no result beat appeared");

endmodule
